>>> rtl/assert_macros.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
// Needs no other file; the modules that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on the module's own clk_i, suspended while rst_ni is low.
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checks a property on an explicitly named clock and active-low reset.
`define UER_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define UER_ASSERT(lbl, prop, msg)
`define UER_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

`endif

>>> rtl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
// Has no dependencies; every RTL module of the block refers to it by scoped names.
`default_nettype none

package uer_pkg;

  // Widths fixed by the register and result fields.
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned OBS_W   = 10;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned CM_W    = 13;
  localparam int unsigned HUND_W  = 7;
  localparam int unsigned TENS_W  = 10;
  localparam int unsigned DIGIT_W = 4;

  // Register file layout.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SCALE    = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_OBSTACLE = 2'd2,
    REG_GAP      = 2'd3
  } reg_idx_e;

  // Register reset values.
  localparam logic [SCALE_W-1:0] SCALE_RST   = 4'd3;
  localparam logic [CNT_W-1:0]   TIMEOUT_RST = 16'd20000;
  localparam logic [OBS_W-1:0]   OBSTACLE_RST = 10'd13;
  localparam logic [TICK_W-1:0]  GAP_RST     = 20'd100000;

  // Reciprocal constants: floor(x/10) = (x*52429)>>19 for x below 2^16,
  // floor(x/100) = (x*5243)>>19 for x below 2^13.
  localparam logic [15:0] DIV10_MUL  = 16'd52429;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_divisor;
    logic [CNT_W-1:0]   timeout_ticks;
    logic [OBS_W-1:0]   obstacle_cm;
    logic [TICK_W-1:0]  gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   echo_count;
    logic [CM_W-1:0]    distance_cm;
    logic [HUND_W-1:0]  digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_units;
    logic               obstacle;
    logic               timed_out;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic cm_en;
    logic dig_en;
    logic save_en;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic finish;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/uer_regs.sv
// Configuration register file of the echo ranger behind an APB-style port.
// Depends on uer_pkg for the register layout and reset values.
`default_nettype none

module uer_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uer_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [uer_pkg::DATA_W-1:0]  pwdata,
  output logic      [uer_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output uer_pkg::cfg_t                    cfg_o
);

  uer_pkg::cfg_t    cfg_q;
  uer_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = uer_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_divisor <= uer_pkg::SCALE_RST;
      cfg_q.timeout_ticks <= uer_pkg::TIMEOUT_RST;
      cfg_q.obstacle_cm   <= uer_pkg::OBSTACLE_RST;
      cfg_q.gap_ticks     <= uer_pkg::GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        uer_pkg::REG_SCALE:    cfg_q.scale_divisor <= pwdata[uer_pkg::SCALE_W-1:0];
        uer_pkg::REG_TIMEOUT:  cfg_q.timeout_ticks <= pwdata[uer_pkg::CNT_W-1:0];
        uer_pkg::REG_OBSTACLE: cfg_q.obstacle_cm   <= pwdata[uer_pkg::OBS_W-1:0];
        uer_pkg::REG_GAP:      cfg_q.gap_ticks     <= pwdata[uer_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    prdata = '0;
    unique case (idx)
      uer_pkg::REG_SCALE:    prdata = 32'(cfg_q.scale_divisor);
      uer_pkg::REG_TIMEOUT:  prdata = 32'(cfg_q.timeout_ticks);
      uer_pkg::REG_OBSTACLE: prdata = 32'(cfg_q.obstacle_cm);
      uer_pkg::REG_GAP:      prdata = 32'(cfg_q.gap_ticks);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/uer_div.sv
// Restoring serial divider: one quotient bit per cycle for the echo count.
// Depends on uer_pkg for the count and divisor widths.
`default_nettype none

module uer_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [uer_pkg::CNT_W-1:0]    dividend_i,
  input  wire logic [uer_pkg::SCALE_W-1:0]  divisor_i,
  output logic      [uer_pkg::CNT_W-1:0]    quot_o,
  output logic                              done_o
);

  localparam int unsigned STEP_W = $clog2(uer_pkg::CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(uer_pkg::CNT_W - 1);

  logic                        busy_q, busy_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [uer_pkg::SCALE_W-1:0] rem_q, rem_d;
  logic [uer_pkg::SCALE_W-1:0] dvs_q, dvs_d;
  logic [uer_pkg::CNT_W-1:0]   quo_q, quo_d;
  logic [uer_pkg::SCALE_W:0]   trial;
  logic                        ge;

  assign trial  = {rem_q, quo_q[uer_pkg::CNT_W-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (step_q == LAST_STEP);
  assign quot_o = quo_q;

  // One shift-and-subtract step per cycle; the dividend shifts out as the
  // quotient shifts in.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? uer_pkg::SCALE_W'(trial - {1'b0, dvs_q})
                  : trial[uer_pkg::SCALE_W-1:0];
      quo_d  = {quo_q[uer_pkg::CNT_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

endmodule

`default_nettype wire

>>> rtl/uer_dp.sv
// Datapath of the echo ranger: tick phase sequencing, echo counting, the
// distance and digit arithmetic, the last-result store and the output register.
// Depends on uer_pkg and instantiates uer_div.
`default_nettype none
`include "assert_macros.svh"

module uer_dp #(
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned SETTLE_TICKS = 2,
  parameter int unsigned PULSE_TICKS  = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  uer_pkg::cfg_t            cfg_i,
  input  uer_pkg::ctrl_cmd_t       cmd_i,
  output uer_pkg::dp_status_t      status_o,
  input  wire logic                echo_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     out_trig_o,
  output logic                     out_done_o,
  output uer_pkg::res_t            out_res_o
);

  localparam int unsigned LW = (COUNT_BITS > uer_pkg::CNT_W) ? COUNT_BITS : uer_pkg::CNT_W;
  localparam logic [LW-1:0] CMASK = {LW{1'b1}} >> (LW - COUNT_BITS);
  localparam logic [uer_pkg::TICK_W-1:0] SETTLE_W = uer_pkg::TICK_W'(SETTLE_TICKS);
  localparam logic [uer_pkg::TICK_W-1:0] PULSE_W  = uer_pkg::TICK_W'(PULSE_TICKS);

  typedef enum logic [2:0] {
    PH_SETTLE = 3'd0,
    PH_PULSE  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_COUNT  = 3'd3,
    PH_GAP    = 3'd4
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [uer_pkg::TICK_W-1:0]  ticks_q, ticks_d, ticks_inc;
  logic [COUNT_BITS-1:0]       pulse_q, pulse_d;
  logic [LW-1:0]               limit, pc_base, pc_inc;
  logic [LW-1:0]               cnt_next;
  logic                        trig, fin, hit;

  // Measurement in flight.
  logic [uer_pkg::CNT_W-1:0]   cnt_q;
  logic                        hit_q;
  logic                        trig_q;
  logic [uer_pkg::CNT_W-1:0]   quot;
  logic                        div_done;
  logic [uer_pkg::SCALE_W-1:0] scale_eff;
  logic [31:0]                 prod_cm;
  logic [uer_pkg::CM_W-1:0]    cm_q;
  logic [28:0]                 prod_q10;
  logic [25:0]                 prod_q100;
  logic [uer_pkg::TENS_W-1:0]  q10_q;
  logic [uer_pkg::HUND_W-1:0]  q100_q;
  logic                        obs_q;
  logic [uer_pkg::TENS_W-1:0]  tens_full;
  logic [uer_pkg::CM_W-1:0]    units_full;

  uer_pkg::res_t               last_q, new_res;
  logic                        out_valid_q;
  logic                        out_trig_q;
  logic                        out_done_q;
  uer_pkg::res_t               out_res_q;
  logic                        out_free;

  // Effective count limit: timeout clamped to the counter range.
  always_comb begin
    limit = LW'(cfg_i.timeout_ticks);
    if (limit > CMASK) begin
      limit = CMASK;
    end
  end

  assign ticks_inc = ticks_q + 1'b1;
  assign pc_base   = (phase_q == PH_WAIT) ? '0 : LW'(pulse_q);
  assign pc_inc    = (pc_base < limit) ? (pc_base + 1'b1) : pc_base;

  // Next phase for one tick.
  always_comb begin
    trig    = 1'b0;
    fin     = 1'b0;
    hit     = 1'b0;
    phase_d = phase_q;
    ticks_d = ticks_q;
    pulse_d = pulse_q;
    unique case (phase_q) inside
      PH_PULSE: begin
        trig = 1'b1;
        if (ticks_inc >= PULSE_W) begin
          phase_d = PH_WAIT;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
      PH_WAIT, PH_COUNT: begin
        if (echo_i) begin
          phase_d = PH_COUNT;
          pulse_d = COUNT_BITS'(pc_inc);
          if (pc_inc >= limit) begin
            fin = 1'b1;
            hit = 1'b1;
          end
        end else if (phase_q == PH_COUNT) begin
          fin = 1'b1;
        end
        if (fin) begin
          ticks_d = '0;
          phase_d = (cfg_i.gap_ticks == '0) ? PH_SETTLE : PH_GAP;
        end
      end
      PH_GAP: begin
        if (ticks_inc >= cfg_i.gap_ticks) begin
          phase_d = PH_SETTLE;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
      default: begin
        // Settle phase; an unknown code restarts it, counting that tick as its first.
        if (phase_q != PH_SETTLE) begin
          if (SETTLE_W <= 1) begin
            phase_d = PH_PULSE;
            ticks_d = '0;
          end else begin
            phase_d = PH_SETTLE;
            ticks_d = 20'd1;
          end
        end else if (ticks_inc >= SETTLE_W) begin
          phase_d = PH_PULSE;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
    endcase
  end

  // Phase registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SETTLE;
      ticks_q <= '0;
      pulse_q <= '0;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      pulse_q <= pulse_d;
    end
  end

  // The count a measurement ends with: the updated count on a high tick, the
  // held count when the echo falls.
  assign cnt_next = LW'(pulse_d);

  // Capture of the finished measurement.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      cnt_q  <= cnt_next[uer_pkg::CNT_W-1:0];
      hit_q  <= hit;
      trig_q <= trig;
    end
  end

  assign scale_eff = (cfg_i.scale_divisor == '0) ? 4'd1 : cfg_i.scale_divisor;

  uer_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cnt_next[uer_pkg::CNT_W-1:0]),
    .divisor_i  (scale_eff),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // Distance in cm, then its quotients by ten and a hundred.
  assign prod_cm   = quot * uer_pkg::DIV10_MUL;
  assign prod_q10  = cm_q * uer_pkg::DIV10_MUL;
  assign prod_q100 = cm_q * uer_pkg::DIV100_MUL;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cm_en) begin
      cm_q <= prod_cm[31:uer_pkg::RECIP_SHIFT];
    end
    if (cmd_i.dig_en) begin
      q10_q  <= prod_q10[28:uer_pkg::RECIP_SHIFT];
      q100_q <= prod_q100[25:uer_pkg::RECIP_SHIFT];
      obs_q  <= cm_q < uer_pkg::CM_W'(cfg_i.obstacle_cm);
    end
  end

  // Digits: remainders after the quotients, each times ten by shift and add.
  assign tens_full  = q10_q - ((uer_pkg::TENS_W'(q100_q) << 3) + (uer_pkg::TENS_W'(q100_q) << 1));
  assign units_full = cm_q - ((uer_pkg::CM_W'(q10_q) << 3) + (uer_pkg::CM_W'(q10_q) << 1));

  always_comb begin
    new_res.echo_count     = cnt_q;
    new_res.distance_cm    = cm_q;
    new_res.digit_hundreds = q100_q;
    new_res.digit_tens     = tens_full[uer_pkg::DIGIT_W-1:0];
    new_res.digit_units    = units_full[uer_pkg::DIGIT_W-1:0];
    new_res.obstacle       = obs_q;
    new_res.timed_out      = hit_q;
  end

  // Last completed measurement, all zero before the first one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.save_en) begin
      last_q <= new_res;
    end
  end

  // Output register: an ordinary tick loads at accept, a finishing tick at save.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !fin) || cmd_i.save_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_en) begin
      out_trig_q <= trig_q;
      out_done_q <= 1'b1;
      out_res_q  <= new_res;
    end else if (cmd_i.accept && !fin) begin
      out_trig_q <= trig;
      out_done_q <= 1'b0;
      out_res_q  <= last_q;
    end
  end

  assign status_o.finish   = fin;
  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;
  assign out_valid_o = out_valid_q;
  assign out_trig_o  = out_trig_q;
  assign out_done_o  = out_done_q;
  assign out_res_o   = out_res_q;

  `UER_ASSERT(a_digits_decimal,
              out_valid_q && out_done_q |->
                (out_res_q.digit_tens <= 4'd9 && out_res_q.digit_units <= 4'd9),
              "decimal digit out of range")
  `UER_ASSERT(a_finish_leaves_count,
              cmd_i.accept && fin |=> (phase_q == PH_GAP || phase_q == PH_SETTLE),
              "measurement end did not leave the count phase")
  `UER_ASSERT(a_count_nonzero,
              phase_q == PH_COUNT |-> pulse_q != '0,
              "count phase entered without a counted tick")

endmodule

`default_nettype wire

>>> rtl/uer_ctrl.sv
// Controller of the echo ranger: input handshake and the sequence of
// divide, distance, digit and save steps after a finished measurement.
// Depends on uer_pkg for the command and status structs.
`default_nettype none
`include "assert_macros.svh"

module uer_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  uer_pkg::dp_status_t status_i,
  output uer_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_TICK = 3'd0,
    ST_DIV  = 3'd1,
    ST_CM   = 3'd2,
    ST_DIG  = 3'd3,
    ST_SAVE = 3'd4
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == ST_TICK) && status_i.out_free;
  assign in_ready_o = ready;

  // Commands and next state.
  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    unique case (state_q)
      ST_TICK: begin
        cmd_o.accept = in_valid_i && ready;
        if (cmd_o.accept && status_i.finish) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_CM;
        end
      end
      ST_CM: begin
        cmd_o.cm_en = 1'b1;
        state_d     = ST_DIG;
      end
      ST_DIG: begin
        cmd_o.dig_en = 1'b1;
        state_d      = ST_SAVE;
      end
      ST_SAVE: begin
        if (status_i.out_free) begin
          cmd_o.save_en = 1'b1;
          state_d       = ST_TICK;
        end
      end
      default: state_d = ST_TICK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TICK;
    end else begin
      state_q <= state_d;
    end
  end

  `UER_ASSERT(a_finish_starts_div, cmd_o.accept && status_i.finish |=> state_q == ST_DIV, "finished measurement did not start the divider")
  `UER_ASSERT(a_div_done_to_cm, state_q == ST_DIV && status_i.div_done |=> state_q == ST_CM, "divider result not taken")
  `UER_ASSERT(a_save_returns, cmd_o.save_en |=> state_q == ST_TICK && !cmd_o.div_start, "save did not return to tick handling")

endmodule

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: register file, controller and datapath.
// Depends on uer_pkg, uer_regs, uer_ctrl, uer_dp and uer_div.
//
// Each input item is one microsecond tick with the sampled echo level, and each
// item yields exactly one result item with the trigger level to drive and the
// last completed measurement. An ordinary tick's result is in the output
// register in the cycle after it is accepted; the input takes a new item
// every cycle while the sink keeps taking results. The tick that ends a
// measurement shows its result only after the serial divider (one quotient bit
// per cycle) has been started and run and the distance multiply, the digit
// multiplies and the save have followed; no further item is accepted until then.
// The user must see that registers are written only while the block idles; the block does not enforce it.
`default_nettype none

module ultrasonic_echo_ranger_unit #(
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned SETTLE_TICKS = 2,
  parameter int unsigned PULSE_TICKS  = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [uer_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [uer_pkg::DATA_W-1:0]  pwdata,
  output logic      [uer_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // Tick input.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [0] echo_level, [7:1] zero
  // Result output.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] trigger_level, [16:1] echo_count, [29:17] distance_cm,
  // [36:30] digit_hundreds, [40:37] digit_tens, [44:41] digit_units,
  // [45] obstacle, [46] timed_out, [47] zero
  output logic      [47:0]                 m_axis_tdata,
  output logic                             m_axis_tuser   // [0] done_res
);

  uer_pkg::cfg_t       cfg;
  uer_pkg::ctrl_cmd_t  cmd;
  uer_pkg::dp_status_t status;
  logic                out_trig;
  logic                out_done;
  uer_pkg::res_t       out_res;

  uer_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  uer_dp #(
    .COUNT_BITS   (COUNT_BITS),
    .SETTLE_TICKS (SETTLE_TICKS),
    .PULSE_TICKS  (PULSE_TICKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .echo_i      (s_axis_tdata[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_trig_o  (out_trig),
    .out_done_o  (out_done),
    .out_res_o   (out_res)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {1'b0,
                         out_res.timed_out,
                         out_res.obstacle,
                         out_res.digit_units,
                         out_res.digit_tens,
                         out_res.digit_hundreds,
                         out_res.distance_cm,
                         out_res.echo_count,
                         out_trig};
  assign m_axis_tuser = out_done;

endmodule

`default_nettype wire
